@@ src/sdspi_pkg.sv @@
// Shared types, codes and helpers for the SD SPI-mode command sequencer.
// No dependencies; used by every module in src/.
package sdspi_pkg;

  // Field widths
  localparam int CMD_W   = 6;
  localparam int ARG_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int S_DATA_W = 56;  // 54 payload bits padded to whole bytes
  localparam int M_DATA_W = 24;  // 17 payload bits padded to whole bytes

  // Action codes carried in s_tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_RX    = 1'b1;

  // Configuration register indexes
  localparam logic REG_READY_LIMIT = 1'b0;
  localparam logic REG_RESP_LIMIT  = 1'b1;

  // Protocol constants
  localparam logic [BYTE_W-1:0] IDLE_BYTE   = 8'hFF;
  localparam logic [BYTE_W-1:0] START_BITS  = 8'h40;
  localparam logic [CMD_W-1:0]  STOP_CMD    = 6'd12;
  localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd100;
  localparam logic [2:0]        CRC_POS     = 3'd5;
  localparam logic [2:0]        STUFF_POS   = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_READY = 3'd2,
    PH_FRAME = 3'd3,
    PH_RESP  = 3'd4
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_TX      = 3'd0,
    K_DONE    = 3'd1,
    K_RDY_TO  = 3'd2,
    K_RESP_TO = 3'd3,
    K_IGNORED = 3'd4
  } kind_t;

  typedef struct packed {
    logic              action;
    logic [CMD_W-1:0]  cmd_index;
    logic [ARG_W-1:0]  argument;
    logic [BYTE_W-1:0] crc_byte;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] tx_byte;
    logic              chip_select_high;
    logic [BYTE_W-1:0] response;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ready_limit;
    logic [BYTE_W-1:0] resp_limit;
  } limits_t;

  // Byte of the six-byte command frame at a given position
  function automatic logic [BYTE_W-1:0] frame_byte(
    input logic [2:0]        pos,
    input logic [CMD_W-1:0]  cmd,
    input logic [ARG_W-1:0]  arg,
    input logic [BYTE_W-1:0] crc
  );
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = {2'b00, cmd} | START_BITS;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

@@ src/sd_spi_command_transaction.sv @@
// Top level of the SD SPI-mode command sequencer: input register, sequencer,
// result register and limit registers. Depends on sdspi_pkg and sdspi_seq.
//
// Usage: each input transfer on s_* is one step. s_tuser = 0 starts a command
// (cmd_index, argument, crc_byte in s_tdata); s_tuser = 1 reports the byte the
// card returned for the previous exchange (rx_byte). Every input transfer gives
// exactly one result transfer on m_*: m_tuser is the kind (transmit, done,
// ready timeout, response timeout, ignored); for a transmit the host shifts
// tx_byte out with the given chip select level and feeds the received byte
// back as the next input.
// Path: an input transfer loads the input register; the item moves on into the
// result register once that has room, and the result is offered from there.
// Throughput: one item per cycle while m_tready does not stall the result,
// set by the combinational phase decision between the two registers.
// Reset: sequencer idle, both pipeline registers empty, both poll limits 100.
// A stalled m_tready holds the result; the input register still takes one more
// item, then s_tready drops until the result is taken.
// The user must write limits on cfg_* only while the block has no item in flight; the block does not enforce it.
module sd_spi_command_transaction (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sdspi_pkg::S_DATA_W-1:0]    s_tdata,  // cmd_index, argument, crc_byte, rx_byte
  input  logic                              s_tuser,  // action
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sdspi_pkg::M_DATA_W-1:0]    m_tdata,  // tx_byte, chip_select_high, response
  output logic [sdspi_pkg::KIND_W-1:0]      m_tuser,  // kind
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sdspi_pkg::BYTE_W-1:0]      cfg_data
);

  sdspi_pkg::item_t   in_item;
  logic               in_valid;
  sdspi_pkg::result_t step_result;
  sdspi_pkg::result_t out_result;
  sdspi_pkg::limits_t limits;
  logic               advance;

  // Move the held item into the result register when it has room
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action    <= s_tuser;
      in_item.cmd_index <= s_tdata[5:0];
      in_item.argument  <= s_tdata[37:6];
      in_item.crc_byte  <= s_tdata[45:38];
      in_item.rx_byte   <= s_tdata[53:46];
    end
  end

  sdspi_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .limits (limits),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tuser = out_result.kind;
  assign m_tdata = {7'b0, out_result.response, out_result.chip_select_high,
                    out_result.tx_byte};

  // Poll limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.ready_limit <= sdspi_pkg::LIMIT_RESET;
      limits.resp_limit  <= sdspi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sdspi_pkg::REG_READY_LIMIT: limits.ready_limit <= cfg_data;
        sdspi_pkg::REG_RESP_LIMIT:  limits.resp_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/sdspi_seq.sv @@
// Command sequencer state and per-byte decision logic.
// Depends on sdspi_pkg.
module sdspi_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,      // consume item this cycle
  input  sdspi_pkg::item_t   item,
  input  sdspi_pkg::limits_t limits,
  output sdspi_pkg::result_t result
);

  sdspi_pkg::phase_t                 phase, phase_next;
  logic [2:0]                        frame_pos, frame_pos_next;
  logic [sdspi_pkg::BYTE_W-1:0]      poll_count, poll_count_next;
  logic [sdspi_pkg::CMD_W-1:0]       held_cmd, held_cmd_next;
  logic [sdspi_pkg::ARG_W-1:0]       held_arg, held_arg_next;
  logic [sdspi_pkg::BYTE_W-1:0]      held_crc, held_crc_next;

  logic rx_idle;
  logic ready_expired;
  logic resp_expired;

  assign rx_idle       = (item.rx_byte == sdspi_pkg::IDLE_BYTE);
  assign ready_expired = (poll_count >= limits.ready_limit);
  assign resp_expired  = (poll_count >= limits.resp_limit);

  // Next state
  always_comb begin
    phase_next      = phase;
    frame_pos_next  = frame_pos;
    poll_count_next = poll_count;
    held_cmd_next   = held_cmd;
    held_arg_next   = held_arg;
    held_crc_next   = held_crc;
    if (item.action == sdspi_pkg::ACT_START) begin
      held_cmd_next   = item.cmd_index;
      held_arg_next   = item.argument;
      held_crc_next   = item.crc_byte;
      frame_pos_next  = 3'd0;
      poll_count_next = '0;
      phase_next      = sdspi_pkg::PH_PRE;
    end else begin
      case (phase)
        sdspi_pkg::PH_PRE: begin
          phase_next      = sdspi_pkg::PH_READY;
          poll_count_next = '0;
        end
        sdspi_pkg::PH_READY: begin
          if (rx_idle) begin
            phase_next     = sdspi_pkg::PH_FRAME;
            frame_pos_next = 3'd0;
          end else if (ready_expired) begin
            phase_next = sdspi_pkg::PH_IDLE;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        sdspi_pkg::PH_FRAME: begin
          if (frame_pos < sdspi_pkg::CRC_POS) begin
            frame_pos_next = frame_pos + 3'd1;
          end else if (frame_pos == sdspi_pkg::CRC_POS && held_cmd == sdspi_pkg::STOP_CMD) begin
            frame_pos_next = sdspi_pkg::STUFF_POS;
          end else begin
            phase_next      = sdspi_pkg::PH_RESP;
            poll_count_next = '0;
          end
        end
        sdspi_pkg::PH_RESP: begin
          if (resp_expired) begin
            phase_next = sdspi_pkg::PH_IDLE;
          end else begin
            poll_count_next = poll_count + 8'd1;
            if (!item.rx_byte[7]) phase_next = sdspi_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = sdspi_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result for this byte
  always_comb begin
    result.kind             = sdspi_pkg::K_TX;
    result.tx_byte          = sdspi_pkg::IDLE_BYTE;
    result.chip_select_high = 1'b0;
    result.response         = '0;
    if (item.action == sdspi_pkg::ACT_START) begin
      result.chip_select_high = 1'b1;
    end else begin
      case (phase)
        sdspi_pkg::PH_PRE: ;
        sdspi_pkg::PH_READY: begin
          if (rx_idle) begin
            result.tx_byte = sdspi_pkg::frame_byte(3'd0, held_cmd, held_arg, held_crc);
          end else if (ready_expired) begin
            result.kind     = sdspi_pkg::K_RDY_TO;
            result.tx_byte  = '0;
            result.response = sdspi_pkg::IDLE_BYTE;
          end
        end
        sdspi_pkg::PH_FRAME: begin
          if (frame_pos < sdspi_pkg::CRC_POS) begin
            result.tx_byte = sdspi_pkg::frame_byte(frame_pos + 3'd1, held_cmd, held_arg,
                                                   held_crc);
          end
        end
        sdspi_pkg::PH_RESP: begin
          if (resp_expired) begin
            result.kind     = sdspi_pkg::K_RESP_TO;
            result.tx_byte  = '0;
            result.response = sdspi_pkg::IDLE_BYTE;
          end else if (!item.rx_byte[7]) begin
            result.kind     = sdspi_pkg::K_DONE;
            result.tx_byte  = '0;
            result.response = item.rx_byte;
          end
        end
        default: begin
          result.kind    = sdspi_pkg::K_IGNORED;
          result.tx_byte = '0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sdspi_pkg::PH_IDLE;
      frame_pos  <= 3'd0;
      poll_count <= '0;
      held_cmd   <= '0;
      held_arg   <= '0;
      held_crc   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      frame_pos  <= frame_pos_next;
      poll_count <= poll_count_next;
      held_cmd   <= held_cmd_next;
      held_arg   <= held_arg_next;
      held_crc   <= held_crc_next;
    end
  end

endmodule

@@ src/sdspi_check.sv @@
// Port-level checker for the SD SPI-mode command sequencer, bound to the top.
// Depends on sdspi_pkg.
module sdspi_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [sdspi_pkg::M_DATA_W-1:0] m_tdata,
  input logic [sdspi_pkg::KIND_W-1:0]   m_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Nothing offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Non-transmit results carry no byte and keep chip select low
  a_no_tx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sdspi_pkg::K_TX |-> m_tdata[8:0] == 9'd0)
    else $error("tx fields set on non-transmit result");

  // Timeouts report 0xFF
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sdspi_pkg::K_RDY_TO || m_tuser == sdspi_pkg::K_RESP_TO)
    |-> m_tdata[16:9] == sdspi_pkg::IDLE_BYTE)
    else $error("timeout without 0xFF response");

  // Deselected exchange only sends the idle byte
  a_desel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tuser == sdspi_pkg::K_TX &&
                               m_tdata[7:0] == sdspi_pkg::IDLE_BYTE)
    else $error("chip select high on non-idle exchange");

endmodule

bind sd_spi_command_transaction sdspi_check u_sdspi_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sd_spi_command_transaction: plays command starts and
// card bytes into the sequencer, predicts each reply and checks it. Needs sdspi_pkg.
module testbench;
  import sdspi_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_ITEMS  = 1900;
  localparam int PHASES      = 6;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic                s_tuser   = ACT_START;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]   m_tuser;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = REG_READY_LIMIT;
  logic [BYTE_W-1:0]   cfg_data  = '0;

  sd_spi_command_transaction u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // cmd_index, argument, crc_byte, rx_byte
    .s_tuser  (s_tuser),   // action
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // tx_byte, chip_select_high, response
    .m_tuser  (m_tuser),   // kind
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Sequencer state as the predictor tracks it
  phase_t            seq_phase   = PH_IDLE;
  logic [2:0]        seq_pos     = '0;
  logic [BYTE_W-1:0] seq_polls   = '0;
  logic [CMD_W-1:0]  seq_cmd     = '0;
  logic [ARG_W-1:0]  seq_arg     = '0;
  logic [BYTE_W-1:0] seq_crc     = '0;
  logic [BYTE_W-1:0] ready_limit = LIMIT_RESET;
  logic [BYTE_W-1:0] resp_limit  = LIMIT_RESET;

  item_t   host_steps[$];          // steps waiting to be sent
  result_t predicted_replies[$];   // replies owed by the sequencer

  int steps_added = 0;
  int step_cut    = -1;            // -1: no truncation of the current command
  int errors      = 0;
  int cycles      = 0;
  int n_starts = 0, n_done = 0, n_rdy_to = 0, n_resp_to = 0, n_ignored = 0;
  int send_gap = 0, send_calm = 0, recv_hold = 0, recv_calm = 0;

  // Byte of the command frame at a position: index|0x40, argument MSB first, CRC
  function automatic logic [BYTE_W-1:0] frame_octet(input logic [2:0] pos);
    logic [39:0] frame;
    frame = {START_BITS | {2'b00, seq_cmd}, seq_arg};
    if (pos >= CRC_POS) return seq_crc;
    return frame[8 * (4 - int'(pos)) +: 8];
  endfunction

  // Advance the predicted sequencer by one step and return its reply
  function automatic result_t next_reply(input item_t it);
    result_t r;
    r = '0;
    r.kind = K_TX;
    if (it.action == ACT_START) begin
      seq_cmd   = it.cmd_index;
      seq_arg   = it.argument;
      seq_crc   = it.crc_byte;
      seq_pos   = '0;
      seq_polls = '0;
      seq_phase = PH_PRE;
      r.tx_byte = IDLE_BYTE;
      r.chip_select_high = 1'b1;
    end else begin
      case (seq_phase)
        PH_PRE: begin
          seq_phase = PH_READY;
          seq_polls = '0;
          r.tx_byte = IDLE_BYTE;
        end
        PH_READY: begin
          if (it.rx_byte == IDLE_BYTE) begin
            seq_phase = PH_FRAME;
            seq_pos   = '0;
            r.tx_byte = frame_octet(3'd0);
          end else if (seq_polls >= ready_limit) begin
            seq_phase  = PH_IDLE;
            r.kind     = K_RDY_TO;
            r.response = IDLE_BYTE;
          end else begin
            seq_polls = seq_polls + 1'b1;
            r.tx_byte = IDLE_BYTE;
          end
        end
        PH_FRAME: begin
          if (seq_pos < CRC_POS) begin
            seq_pos   = seq_pos + 1'b1;
            r.tx_byte = frame_octet(seq_pos);
          end else if (seq_pos == CRC_POS && seq_cmd == STOP_CMD) begin
            seq_pos   = STUFF_POS;   // extra stuff byte after a stop command
            r.tx_byte = IDLE_BYTE;
          end else begin
            seq_phase = PH_RESP;
            seq_polls = '0;
            r.tx_byte = IDLE_BYTE;
          end
        end
        PH_RESP: begin
          if (seq_polls >= resp_limit) begin
            seq_phase  = PH_IDLE;
            r.kind     = K_RESP_TO;
            r.response = IDLE_BYTE;
          end else begin
            seq_polls = seq_polls + 1'b1;
            if (!it.rx_byte[7]) begin
              seq_phase  = PH_IDLE;
              r.kind     = K_DONE;
              r.response = it.rx_byte;
            end else begin
              r.tx_byte = IDLE_BYTE;
            end
          end
        end
        default: begin
          seq_phase = PH_IDLE;
          r.kind    = K_IGNORED;
        end
      endcase
    end
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Input driver
  always @(posedge clk) begin : drive
    item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (host_steps.size() != 0) begin
        nxt = host_steps.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, nxt.rx_byte, nxt.crc_byte, nxt.argument, nxt.cmd_index};
        s_tuser  <= nxt.action;
        if (send_calm != 0) begin
          send_gap  <= 0;
          send_calm <= send_calm - 1;
        end else begin
          send_gap <= idle_len();
          if ($urandom_range(99) < 2) send_calm <= $urandom_range(20, 60);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin : backpressure
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold != 0) begin
      m_tready  <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (recv_calm != 0) begin
      m_tready  <= 1'b1;
      recv_calm <= recv_calm - 1;
    end else begin
      stall = ($urandom_range(99) < 40) ? idle_len() : 0;
      if (stall == 0) begin
        m_tready <= 1'b1;
        if ($urandom_range(99) < 2) recv_calm <= $urandom_range(20, 60);
      end else begin
        m_tready  <= 1'b0;
        recv_hold <= stall - 1;
      end
    end
  end

  // Monitor: check result transfers, predict on input transfers
  always @(posedge clk) begin : scoreboard
    item_t   seen;
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (predicted_replies.size() == 0) begin
          $error("unexpected result: kind %0d tdata %h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
            errors++;
          end
          if (m_tdata[7:0] !== want.tx_byte) begin
            $error("tx_byte: expected %h, actual %h", want.tx_byte, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[8] !== want.chip_select_high) begin
            $error("chip_select_high: expected %b, actual %b", want.chip_select_high,
                   m_tdata[8]);
            errors++;
          end
          if (m_tdata[16:9] !== want.response) begin
            $error("response: expected %h, actual %h", want.response, m_tdata[16:9]);
            errors++;
          end
          case (want.kind)
            K_DONE:    n_done++;
            K_RDY_TO:  n_rdy_to++;
            K_RESP_TO: n_resp_to++;
            K_IGNORED: n_ignored++;
            default: ;
          endcase
        end
      end
      if (s_tvalid && s_tready) begin
        seen.action    = s_tuser;
        seen.cmd_index = s_tdata[5:0];
        seen.argument  = s_tdata[37:6];
        seen.crc_byte  = s_tdata[45:38];
        seen.rx_byte   = s_tdata[53:46];
        if (seen.action == ACT_START) n_starts++;
        predicted_replies.push_back(next_reply(seen));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sd_spi_command_transaction regression: fail");
      $finish;
    end
  end

  task automatic push_step(input logic act, input logic [CMD_W-1:0] cmd,
                           input logic [ARG_W-1:0] arg, input logic [BYTE_W-1:0] crc,
                           input logic [BYTE_W-1:0] rx);
    item_t it;
    if (step_cut != 0) begin
      it.action    = act;
      it.cmd_index = cmd;
      it.argument  = arg;
      it.crc_byte  = crc;
      it.rx_byte   = rx;
      host_steps.push_back(it);
      steps_added++;
      if (step_cut > 0) step_cut--;
    end
  endtask

  task automatic push_start(input logic [CMD_W-1:0] cmd, input logic [ARG_W-1:0] arg,
                            input logic [BYTE_W-1:0] crc);
    push_step(ACT_START, cmd, arg, crc, 8'($urandom_range(255)));
  endtask

  // Card byte; the start-only fields carry junk
  task automatic push_card_byte(input logic [BYTE_W-1:0] rx);
    push_step(ACT_RX, 6'($urandom_range(63)), $urandom, 8'($urandom_range(255)), rx);
  endtask

  // Full exchange as a card would answer: busy bytes, ready, frame, R1 or timeouts
  task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [ARG_W-1:0] arg,
                             input logic [BYTE_W-1:0] crc, input int busy, input bit rdy_ok,
                             input int waits, input bit ans, input logic [BYTE_W-1:0] r1);
    int busy_n, wait_n;
    bit answers;
    busy_n  = rdy_ok ? ((busy > int'(ready_limit)) ? int'(ready_limit) : busy)
                     : int'(ready_limit) + 1;
    answers = ans && (resp_limit != 0);
    wait_n  = answers ? ((waits >= int'(resp_limit)) ? int'(resp_limit) - 1 : waits)
                      : int'(resp_limit);
    push_start(cmd, arg, crc);
    push_card_byte(8'($urandom_range(255)));        // preamble byte, not looked at
    repeat (busy_n) push_card_byte(8'($urandom_range(254)));
    if (rdy_ok) begin
      push_card_byte(IDLE_BYTE);
      repeat ((cmd == STOP_CMD) ? 7 : 6) push_card_byte(8'($urandom_range(255)));
      repeat (wait_n) push_card_byte(8'h80 | 8'($urandom_range(127)));
      push_card_byte(answers ? {1'b0, r1[6:0]} : 8'($urandom_range(255)));
    end
  endtask

  // Random command; cut > 0 stops it after that many steps
  task automatic random_command(input int cut);
    logic [CMD_W-1:0] cmd;
    int busy, waits, rare;
    bit rdy_ok, ans;
    cmd    = ($urandom_range(5) == 0) ? STOP_CMD : 6'($urandom_range(63));
    busy   = ($urandom_range(3) == 0) ? $urandom_range(int'(ready_limit)) : $urandom_range(3);
    waits  = ($urandom_range(3) == 0) ? $urandom_range(int'(resp_limit)) : $urandom_range(3);
    rare   = (ready_limit > 50) ? 3 : 12;
    rdy_ok = $urandom_range(99) >= rare;
    rare   = (resp_limit > 50) ? 3 : 12;
    ans    = $urandom_range(99) >= rare;
    step_cut = cut;
    run_command(cmd, $urandom, 8'($urandom_range(255)), busy, rdy_ok, waits, ans,
                8'($urandom_range(127)));
    step_cut = -1;
  endtask

  task automatic random_traffic(input int n);
    int goal, r;
    goal = steps_added + n;
    while (steps_added < goal) begin
      r = $urandom_range(99);
      if (r < 80) begin
        random_command(-1);
      end else if (r < 92) begin
        random_command($urandom_range(1, 12));
      end else begin
        // noise: loose steps of either kind
        repeat ($urandom_range(1, 4))
          push_step(1'($urandom_range(1)), 6'($urandom_range(63)), $urandom,
                    8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic write_limit(input logic idx, input logic [BYTE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_READY_LIMIT) ready_limit = value;
    else resp_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every step is sent and every reply is back, plus a short pause;
  // checked mid-cycle so the driver and monitor updates of an edge have settled
  task automatic drain();
    while (host_steps.size() != 0 || s_tvalid || predicted_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int lim_r, lim_p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, at reset limits: byte while idle, stop command with stuff byte and
    // all-ones fields, a start abandoned mid-poll, then an all-zero command
    push_card_byte(8'h00);
    run_command(STOP_CMD, 32'hFFFF_FFFF, 8'hFF, 1, 1'b1, 1, 1'b1, 8'h7F);
    push_start(6'd63, 32'h0000_0000, 8'h00);
    push_card_byte(8'hA5);
    push_card_byte(8'h00);
    run_command(6'd0, 32'h0000_0000, 8'h00, 0, 1'b1, 0, 1'b1, 8'h00);
    drain();

    // Random phases under different limit settings, extremes included
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin lim_r = 1;   lim_p = 1;   end
        1:       begin lim_r = 255; lim_p = 255; end
        2:       begin lim_r = 0;   lim_p = 0;   end
        3:       begin lim_r = 1;   lim_p = 255; end
        4:       begin lim_r = $urandom_range(1, 255); lim_p = $urandom_range(1, 255); end
        default: begin lim_r = $urandom_range(2, 12);  lim_p = $urandom_range(2, 12);  end
      endcase
      write_limit(REG_READY_LIMIT, 8'(lim_r));
      write_limit(REG_RESP_LIMIT, 8'(lim_p));
      random_traffic(RAND_ITEMS / PHASES);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d command starts: %0d R1 answers, %0d ready and %0d response timeouts",
             n_starts, n_done, n_rdy_to, n_resp_to);
    $display("plus %0d ignored bytes, over %0d limit settings from 0 to 255",
             n_ignored, PHASES + 1);
    if (errors == 0)
      $display("sd_spi_command_transaction regression: pass");
    else
      $display("sd_spi_command_transaction regression: fail");
    $finish;
  end

endmodule
